>>> sv/u8d_pkg.sv
// shared types and constants for the utf-8 byte stream decoder
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int BL_W   = 2;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF4;

    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    localparam logic [BL_W-1:0] BL_IDLE = 2'd0;
    localparam logic [BL_W-1:0] BL_ONE  = 2'd1;
    localparam logic [BL_W-1:0] BL_TWO  = 2'd2;
    localparam logic [BL_W-1:0] BL_THREE = 2'd3;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            invalid;
        logic            end_of_text;
    } t_result;

endpackage

>>> sv/u8d_decode.sv
// utf-8 sequence state and per-byte decode logic
module u8d_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [u8d_pkg::BYTE_W-1:0] i_byte,
    output u8d_pkg::t_result          o_res
);
    import u8d_pkg::*;

    logic [BL_W-1:0] r_bl;
    logic [BL_W-1:0] n_bl;
    logic [CP_W-1:0] r_pv;
    logic [CP_W-1:0] n_pv;
    logic [CP_W-1:0] cont_sh;
    logic [CP_W-1:0] acc;
    t_result         res;

    always_comb begin
        n_bl    = r_bl;
        n_pv    = r_pv;
        res     = '0;
        cont_sh = '0;
        acc     = '0;
        if (r_bl != BL_IDLE) begin
            // continuation byte: low six bits at the next lower slot
            case (r_bl)
                BL_ONE:  cont_sh = {15'b0, i_byte[5:0]};
                BL_TWO:  cont_sh = {9'b0, i_byte[5:0], 6'b0};
                default: cont_sh = {3'b0, i_byte[5:0], 12'b0};
            endcase
            acc  = r_pv | cont_sh;
            n_bl = r_bl - BL_ONE;
            if (n_bl != BL_IDLE) begin
                n_pv = acc;
            end else begin
                n_pv      = '0;
                res.valid = 1'b1;
                if (acc >= SURR_LO && acc <= SURR_HI) begin
                    res.invalid = 1'b1;
                end else begin
                    res.code_point = acc;
                end
            end
        end else if (i_byte == '0) begin
            res.valid       = 1'b1;
            res.end_of_text = 1'b1;
        end else if (!i_byte[BYTE_W-1]) begin
            res.valid      = 1'b1;
            res.code_point = {{(CP_W-BYTE_W){1'b0}}, i_byte};
        end else if ((i_byte & LEAD2_MASK) == LEAD2_CODE) begin
            n_pv = {10'b0, i_byte[4:0], 6'b0};
            n_bl = BL_ONE;
        end else if ((i_byte & LEAD3_MASK) == LEAD3_CODE) begin
            n_pv = {5'b0, i_byte[3:0], 12'b0};
            n_bl = BL_TWO;
        end else if ((i_byte & LEAD4_MASK) == LEAD4_CODE && i_byte <= LEAD4_MAX) begin
            n_pv = {i_byte[2:0], 18'b0};
            n_bl = BL_THREE;
        end else begin
            res.valid   = 1'b1;
            res.invalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl <= BL_IDLE;
            r_pv <= '0;
        end else if (i_en) begin
            r_bl <= n_bl;
            r_pv <= n_pv;
        end
    end

    assign o_res = res;

endmodule

>>> sv/utf8_byte_stream_decoder.sv
// top level of the utf-8 byte stream decoder with skid, input and result registers
// data path: skid entry if needed, input register, decode logic, result register
// throughput: one byte per cycle, sustained, as long as results are taken
// o_stall is registered; it rises only when the skid entry holds a byte
// reset (synchronous, active low) empties all stages and returns to lead-byte wait
module utf8_byte_stream_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [u8d_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [u8d_pkg::CP_W-1:0]    o_code_point,
    output logic                        o_invalid,
    output logic                        o_end_of_text
);
    import u8d_pkg::*;

    // skid entry catches a request that arrives while the input register is held
    logic              r_skid_valid;
    logic [BYTE_W-1:0] r_skid_byte;
    // input register feeding the decode logic
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    // result register
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_invalid;
    logic              r_out_end;

    logic    accept;
    logic    out_free;
    logic    advance;
    logic    in_free;
    t_result dec_res;

    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    u8d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_res   (dec_res)
    );

    // a byte that yields no result never waits on the output side
    assign advance = r_in_valid && (!dec_res.valid || out_free);
    assign in_free = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_in_valid   <= 1'b0;
        end else begin
            if (in_free) begin
                // skid first, it holds the older request
                if (r_skid_valid) begin
                    r_in_valid   <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_in_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in_byte <= r_skid_valid ? r_skid_byte : i_in_byte;
        end
        if (!in_free && accept) begin
            r_skid_byte <= i_in_byte;
        end
    end

    // result register: loaded on a decoded result, emptied when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && dec_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_res.valid) begin
            r_out_cp      <= dec_res.code_point;
            r_out_invalid <= dec_res.invalid;
            r_out_end     <= dec_res.end_of_text;
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_code_point  = r_out_cp;
    assign o_invalid     = r_out_invalid;
    assign o_end_of_text = r_out_end;

    a_skid_behind_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_in_valid)
        else $error("skid entry held with empty input register");

    a_flag_zero_cp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_invalid || r_out_end)) |-> (r_out_cp == '0))
        else $error("nonzero code point on error or end marker");

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_invalid && r_out_end))
        else $error("invalid and end marker both set");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(advance && dec_res.valid))
        else $error("result register overwritten while stalled");

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the utf-8 byte stream decoder
`timescale 1ns / 100ps

module tb_top;
    import u8d_pkg::*;

    // bytes below this value are plain ascii and complete on their own
    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    // cycles with no request moving on either side before the run is called hung
    localparam int IDLE_LIMIT = 2000;
    // how long the receiver holds off once to back the block up into its input
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1000;

    // decodes every accepted byte on its own and keeps the code points that must come out
    class cp_scoreboard;
        logic [BL_W-1:0] bytes_owed;
        logic [CP_W-1:0] cp_accum;
        t_result         owed_cps[$];
        int              errors;

        function new();
            bytes_owed = BL_IDLE;
            cp_accum   = '0;
            errors     = 0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            t_result         r;
            logic [CP_W-1:0] bits6;
            logic [CP_W-1:0] done_cp;
            r       = '0;
            r.valid = 1'b1;
            // inside a sequence: any byte counts, only its low six bits are used
            if (bytes_owed != BL_IDLE) begin
                bits6       = '0;
                bits6[5:0]  = b[5:0];
                cp_accum    = cp_accum | (bits6 << (6 * (bytes_owed - 1)));
                bytes_owed  = bytes_owed - BL_ONE;
                if (bytes_owed != BL_IDLE) return;
                done_cp  = cp_accum;
                cp_accum = '0;
                // surrogate halves never stand as scalar values
                if (done_cp >= SURR_LO && done_cp <= SURR_HI) r.invalid = 1'b1;
                else r.code_point = done_cp;
                owed_cps.push_back(r);
                return;
            end
            if (b == '0) begin
                r.end_of_text = 1'b1;
            end else if (b < ASCII_LIMIT) begin
                r.code_point = {13'd0, b};
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                cp_accum        = '0;
                cp_accum[10:6]  = b[4:0];
                bytes_owed      = BL_ONE;
                return;
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                cp_accum        = '0;
                cp_accum[15:12] = b[3:0];
                bytes_owed      = BL_TWO;
                return;
            end else if ((b & LEAD4_MASK) == LEAD4_CODE && b <= LEAD4_MAX) begin
                cp_accum        = '0;
                cp_accum[20:18] = b[2:0];
                bytes_owed      = BL_THREE;
                return;
            end else begin
                // stray continuation byte or lead above f4: one byte eaten, flagged
                r.invalid = 1'b1;
            end
            owed_cps.push_back(r);
        endfunction

        function void check_result(logic [CP_W-1:0] cp, logic bad, logic eot);
            t_result want;
            if (owed_cps.size() == 0) begin
                $display("%0t: unexpected result cp %h invalid %b end %b", $time, cp, bad, eot);
                errors++;
                return;
            end
            want = owed_cps.pop_front();
            if (cp !== want.code_point) begin
                $display("%0t: code_point expected %h got %h", $time, want.code_point, cp);
                errors++;
            end
            if (bad !== want.invalid) begin
                $display("%0t: invalid expected %b got %b", $time, want.invalid, bad);
                errors++;
            end
            if (eot !== want.end_of_text) begin
                $display("%0t: end_of_text expected %b got %b", $time, want.end_of_text, eot);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [BYTE_W-1:0] i_in_byte;
    logic              o_valid;
    logic              i_stall;
    logic [CP_W-1:0]   o_code_point;
    logic              o_invalid;
    logic              o_end_of_text;

    cp_scoreboard sb;
    int           items_sent;
    int           idle_cycles;
    // quiet turns off idling on both sides; hold_req asks the receiver for one long hold
    bit           quiet;
    bit           hold_req;

    utf8_byte_stream_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_invalid     (o_invalid),
        .o_end_of_text (o_end_of_text)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // mostly no gap, now and then a few cycles, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one byte after an optional gap and hold it until the block takes it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid   = 1'b0;
            i_in_byte = 8'($urandom);
        end
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_in_byte = b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // one character worth of bytes: mostly well formed, some truncated or garbage
    task automatic send_random_char();
        logic [BYTE_W-1:0] seq [4];
        int                n;
        int                kind;
        bit                surr;
        n    = 1;
        surr = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            seq[0] = 8'($urandom_range(1, 127));
        end else if (kind < 28) begin
            seq[0] = '0;
        end else if (kind < 45) begin
            n      = 2;
            seq[0] = {3'b110, 5'($urandom)};
        end else if (kind < 60) begin
            n      = 3;
            seq[0] = {4'b1110, 4'($urandom)};
        end else if (kind < 66) begin
            // lead ed with a second byte in a0..bf lands in the surrogate range
            n      = 3;
            surr   = 1'b1;
            seq[0] = 8'hED;
        end else if (kind < 84) begin
            n      = 4;
            seq[0] = 8'($urandom_range(8'hF0, LEAD4_MAX));
        end else if (kind < 92) begin
            if ($urandom_range(0, 1) == 0) seq[0] = {2'b10, 6'($urandom)};
            else seq[0] = 8'($urandom_range(8'hF5, 8'hFF));
        end else begin
            seq[0] = 8'($urandom);
        end
        for (int i = 1; i < 4; i++) begin
            if ($urandom_range(0, 9) == 0) seq[i] = 8'($urandom);
            else seq[i] = {2'b10, 6'($urandom)};
        end
        if (surr) seq[1] = {3'b101, 5'($urandom)};
        // broken sequence: cut short so the next char lands in continuation position
        if (n > 1 && $urandom_range(0, 19) == 0) n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) send_byte(seq[i]);
    endtask

    // receiver: random stall runs, plus one long hold on request
    initial begin
        int run_left;
        run_left = 0;
        i_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                run_left = HOLD_CYCLES;
            end
            if (run_left > 0) begin
                i_stall = 1'b1;
                run_left--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_stall  = 1'b1;
                run_left = stall_len() - 1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // request monitor on both sides, and the hang watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_byte(i_in_byte);
            if (o_valid && !i_stall) sb.check_result(o_code_point, o_invalid, o_end_of_text);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] directed [27];
        directed = '{
            8'h00,                      // end of text
            8'h41, 8'h7F,               // ascii, top of ascii
            8'hC2, 8'hA9,               // two-byte char
            8'hE2, 8'h82, 8'hAC,        // three-byte char
            8'hF0, 8'h9F, 8'h98, 8'h80, // four-byte char
            8'hED, 8'hA0, 8'h80,        // lowest surrogate
            8'hED, 8'hBF, 8'hBF,        // highest surrogate
            8'h80, 8'hFF, 8'hF5,        // bad leads
            8'hC3, 8'h00,               // zero byte as continuation
            8'hF4, 8'hFF, 8'hFF, 8'hFF  // top decodable value, unchecked top bits
        };
        sb          = new();
        items_sent  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in_byte   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) send_byte(directed[i]);

        while (items_sent < RANDOM_ITEMS + 27) begin
            // a stretch with no idling; inside it the receiver backs up the block once
            if (items_sent >= 400 && items_sent < 550) begin
                quiet = 1'b1;
                if (items_sent >= 450 && items_sent < 454) hold_req = 1'b1;
            end else begin
                quiet = 1'b0;
            end
            send_random_char();
        end
        quiet = 1'b0;

        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.owed_cps.size() != 0) @(posedge i_clk);
        // trailing cycles so a stray extra result would still be caught
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_cps.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
